/* rtl/psc_pkg.sv */
// Shared constants and types for the pixel stream converter.
`timescale 1ns / 1ps

package psc_pkg;

    // Framebuffer geometry in pixels, portrait orientation.
    localparam int FB_WIDTH  = 172;
    localparam int FB_HEIGHT = 320;

    // Counters must hold any column or row index of either orientation.
    localparam int SCREEN_MAX = (FB_WIDTH > FB_HEIGHT) ? FB_WIDTH : FB_HEIGHT;
    localparam int CNT_W      = $clog2(SCREEN_MAX);

    localparam int ADDR_W   = 16;
    localparam int COLOUR_W = 16;

    // Configuration register indexes.
    localparam logic CFG_PIXEL_FORMAT = 1'b0;
    localparam logic CFG_LANDSCAPE    = 1'b1;

    // Pixel format codes.
    localparam logic FMT_RGB332    = 1'b0;
    localparam logic FMT_RGB565_LE = 1'b1;

    // Byte phase codes for the two byte format.
    localparam logic PHASE_LOW  = 1'b0;
    localparam logic PHASE_HIGH = 1'b1;

    typedef logic [CNT_W-1:0] t_count;

    typedef struct packed {
        logic [ADDR_W-1:0]   write_address;
        logic [COLOUR_W-1:0] colour;
        logic                frame_end;
    } t_result;

endpackage

/* rtl/pixel_stream_convert_rotate.sv */
// Top level of the pixel stream converter with quarter turn rotation.
`timescale 1ns / 1ps

// This block turns a stream of video frame bytes into framebuffer writes. Each
// transfer on the input channel carries one byte; each transfer on the output
// channel carries one write (pixel address, RGB565 colour and an end of frame
// flag). In RGB332 mode every byte yields one write, with the color fields
// widened by bit replication. In RGB565 mode bytes pair up low byte first and
// only the high byte yields a write. In landscape mode the source frame is as
// wide as the framebuffer is tall and as tall as the framebuffer is wide, and
// is rotated a quarter turn into the portrait framebuffer. The block takes one
// byte per clock cycle unless two writes wait: the address product and the
// counter update for a byte are combinational between input acceptance and
// the result register, and a skid register behind the result register lets a
// new byte be accepted while a finished write still waits to be taken. A
// result is registered in the output register, or in the skid register while
// that one is full and not taken. Configuration writes through the register
// port take effect in the next cycle and should only be made while no write is
// pending; they never touch the pixel counters or the byte pairing.

module pixel_stream_convert_rotate (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic                          i_cfg_data,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [psc_pkg::ADDR_W-1:0]    o_write_address,
    output logic [psc_pkg::COLOUR_W-1:0]  o_colour,
    output logic                          o_frame_end
);

    localparam int CNT_W  = psc_pkg::CNT_W;
    localparam int ADDR_W = psc_pkg::ADDR_W;

    // Source frame geometry for each orientation, one bit wider than the
    // counters so that the sizes themselves fit.
    localparam logic [CNT_W:0] PORT_COLS = (CNT_W+1)'(psc_pkg::FB_WIDTH);
    localparam logic [CNT_W:0] PORT_ROWS = (CNT_W+1)'(psc_pkg::FB_HEIGHT);
    localparam logic [CNT_W:0] LAND_COLS = (CNT_W+1)'(psc_pkg::FB_HEIGHT);
    localparam logic [CNT_W:0] LAND_ROWS = (CNT_W+1)'(psc_pkg::FB_WIDTH);

    localparam logic [ADDR_W-1:0] WIDTH_A     = ADDR_W'(psc_pkg::FB_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_X_A    = ADDR_W'(psc_pkg::FB_WIDTH - 1);

    // Configuration registers.
    logic r_pixel_format;
    logic r_landscape;

    // Stream state.
    psc_pkg::t_count r_column, n_column;
    psc_pkg::t_count r_row,    n_row;
    logic            r_phase,  n_phase;
    logic [7:0]      r_low_byte;

    // Output register and skid register.
    psc_pkg::t_result r_out, r_skid;
    logic             r_out_valid, r_skid_valid;

    logic             in_xfer;
    logic             out_xfer;
    logic             produce;
    psc_pkg::t_result result;
    logic [15:0]      widened;
    logic [CNT_W:0]   cols, rows;
    logic [ADDR_W-1:0] column_a, row_a;

    // The skid register is free whenever it is empty, so the input side only
    // stalls once two writes are waiting.
    assign o_in_ready = !r_skid_valid;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = r_out_valid && i_out_ready;

    // RGB332 to RGB565 by bit replication of each color field.
    assign widened = {i_data_byte[7:5], i_data_byte[7:6],
                      i_data_byte[4:2], i_data_byte[4:2],
                      i_data_byte[1:0], i_data_byte[1:0], i_data_byte[1]};

    assign cols = r_landscape ? LAND_COLS : PORT_COLS;
    assign rows = r_landscape ? LAND_ROWS : PORT_ROWS;

    assign column_a = ADDR_W'(r_column);
    assign row_a    = ADDR_W'(r_row);

    // Per-byte conversion, address generation and counter stepping. Addresses
    // wrap modulo 2^16, which also covers rows beyond the rotated width.
    always_comb begin
        produce              = 1'b1;
        n_phase              = psc_pkg::PHASE_LOW;
        n_column             = r_column;
        n_row                = r_row;
        result.colour        = widened;
        result.frame_end     = 1'b0;

        if (r_pixel_format == psc_pkg::FMT_RGB565_LE) begin
            if (r_phase == psc_pkg::PHASE_LOW) begin
                produce = 1'b0;
                n_phase = psc_pkg::PHASE_HIGH;
            end else begin
                result.colour = {i_data_byte, r_low_byte};
            end
        end

        if (r_landscape) begin
            result.write_address = column_a * WIDTH_A + (LAST_X_A - row_a);
        end else begin
            result.write_address = row_a * WIDTH_A + column_a;
        end

        if (produce) begin
            if ({1'b0, r_column} + 1'b1 >= cols) begin
                n_column = '0;
                if ({1'b0, r_row} + 1'b1 >= rows) begin
                    n_row            = '0;
                    result.frame_end = 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_column = r_column + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= psc_pkg::FMT_RGB332;
            r_landscape    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psc_pkg::CFG_PIXEL_FORMAT: r_pixel_format <= i_cfg_data;
                psc_pkg::CFG_LANDSCAPE:    r_landscape    <= i_cfg_data;
                default:                   r_landscape    <= r_landscape;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
            r_phase  <= psc_pkg::PHASE_LOW;
        end else if (in_xfer) begin
            r_column <= n_column;
            r_row    <= n_row;
            r_phase  <= n_phase;
        end
    end

    // The held low byte is payload only; the phase says whether it is live.
    always_ff @(posedge i_clk) begin
        if (in_xfer && !produce) begin
            r_low_byte <= i_data_byte;
        end
    end

    // Output register with a skid register behind it. A write lands in the
    // skid register only when the output register is full and not being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_xfer) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_xfer) begin
            r_out_valid <= in_xfer && produce;
        end else if (in_xfer && produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_xfer) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_xfer) begin
            r_out <= result;
        end else begin
            r_skid <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_address = r_out.write_address;
    assign o_colour        = r_out.colour;
    assign o_frame_end     = r_out.frame_end;

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the pixel stream converter with quarter turn rotation.
`timescale 1ns / 1ps

// The bench streams frame bytes into the converter and checks every framebuffer
// write that comes out. It does this in three parts.
//
// Directed tests cover the color extremes in both pixel formats, byte pairing
// and the drop of a dangling low byte, and both orientations. They also walk
// through line ends:
//   - the ordinary end of a portrait line,
//   - a switch back to portrait exactly on the last portrait column,
//   - a switch back to portrait beyond the last portrait column.
//
// The random part runs in three idling phases. Blocks of bytes are broken up
// by register writes and by pauses that let the output drain.
//
// A predictor mirrors the converter state. At each accepted input transfer it
// queues the write that the byte should cause, if any. A checker process
// compares each output transfer, field by field, against the oldest queued
// write.
module testbench;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 6;
    localparam int SETTLE_LEN  = 4;       // margin after the write queue empties
    localparam int CYCLE_LIMIT = 500000;  // watchdog bound on the whole run
    localparam int REPORT_MAX  = 10;

    // Every input of the block starts at a known value.
    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_we    = 1'b0;
    logic                         i_cfg_index = psc_pkg::CFG_PIXEL_FORMAT;
    logic                         i_cfg_data  = psc_pkg::FMT_RGB332;
    logic                         i_in_valid  = 1'b0;
    logic [7:0]                   i_data_byte = 8'h00;
    logic                         i_out_ready = 1'b0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic [psc_pkg::ADDR_W-1:0]   o_write_address;
    logic [psc_pkg::COLOUR_W-1:0] o_colour;
    logic                         o_frame_end;

    pixel_stream_convert_rotate i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_write_address (o_write_address),
        .o_colour        (o_colour),
        .o_frame_end     (o_frame_end)
    );

    // Predicted converter state. It starts at the reset values of the block.
    logic       cur_format    = psc_pkg::FMT_RGB332;
    logic       cur_landscape = 1'b0;
    logic       pair_phase    = psc_pkg::PHASE_LOW;
    logic [7:0] low_byte      = 8'h00;
    int         src_col       = 0;
    int         src_row       = 0;

    // Writes that are predicted but not yet seen, oldest first.
    psc_pkg::t_result pending_writes[$];

    int in_idle_pct     = 0;
    int out_idle_pct    = 0;
    int cycle_count     = 0;
    int bytes_sent      = 0;
    int writes_checked  = 0;
    int frames_seen     = 0;
    int bad_writes      = 0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The receiver stalls at random. The rate is set per test phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // RGB332 to RGB565 by bit replication. Red and blue take their top bits
    // again at the bottom; green repeats its three bits.
    function automatic logic [15:0] widen_rgb332(input logic [7:0] b);
        logic [4:0] red5;
        logic [5:0] green6;
        logic [4:0] blue5;
        red5   = {b[7:5], b[7:6]};
        green6 = {b[4:2], b[4:2]};
        blue5  = {b[1:0], b[1:0], b[1]};
        return {red5, green6, blue5};
    endfunction

    // Advances the predicted state by one byte and queues the write it causes.
    // The counters wrap against the source frame size of the current orientation.
    // A column past that size, left over from an orientation switch in mid frame,
    // ends its line at once; a row past it ends the frame at the end of that line.
    task automatic convert_byte(input logic [7:0] b);
        logic [15:0]      colour;
        int               cols;
        int               rows;
        int               addr;
        psc_pkg::t_result w;
        if (cur_format == psc_pkg::FMT_RGB332) begin
            pair_phase = psc_pkg::PHASE_LOW;
            colour     = widen_rgb332(b);
        end else if (pair_phase == psc_pkg::PHASE_LOW) begin
            low_byte   = b;
            pair_phase = psc_pkg::PHASE_HIGH;
            return;
        end else begin
            colour     = {b, low_byte};
            pair_phase = psc_pkg::PHASE_LOW;
        end

        if (cur_landscape) begin
            cols = psc_pkg::FB_HEIGHT;
            rows = psc_pkg::FB_WIDTH;
            addr = src_col * psc_pkg::FB_WIDTH + (psc_pkg::FB_WIDTH - 1 - src_row);
        end else begin
            cols = psc_pkg::FB_WIDTH;
            rows = psc_pkg::FB_HEIGHT;
            addr = src_row * psc_pkg::FB_WIDTH + src_col;
        end

        // Rows past the rotated width wrap below zero.
        w.write_address = addr[psc_pkg::ADDR_W-1:0];
        w.colour        = colour;
        w.frame_end     = 1'b0;
        if (src_col + 1 >= cols) begin
            src_col = 0;
            if (src_row + 1 >= rows) begin
                src_row     = 0;
                w.frame_end = 1'b1;
            end else begin
                src_row++;
            end
        end else begin
            src_col++;
        end
        pending_writes.push_back(w);
    endtask

    // Checks each output transfer against the oldest predicted write.
    always @(posedge i_clk) begin : check_writes
        psc_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_writes.size() == 0) begin
                if (bad_writes < REPORT_MAX)
                    $display("t=%0t unexpected write: addr=%0d colour=%h end=%0b",
                             $realtime, o_write_address, o_colour, o_frame_end);
                bad_writes++;
            end else begin
                want = pending_writes.pop_front();
                writes_checked++;
                if (o_frame_end)
                    frames_seen++;
                if (o_write_address !== want.write_address || o_colour !== want.colour
                        || o_frame_end !== want.frame_end) begin
                    if (bad_writes < REPORT_MAX)
                        $display("t=%0t mismatch: want %0d %h %0b, got %0d %h %0b",
                                 $realtime, want.write_address, want.colour,
                                 want.frame_end, o_write_address, o_colour, o_frame_end);
                    bad_writes++;
                end
            end
        end
    end

    // Holds the sender off until every predicted write has come out. A
    // dangling low byte causes no write, so the task still waits after the
    // queue empties to let the block finish with it.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_LEN) @(posedge i_clk);
    endtask

    // Registers are only written with the block idle.
    task automatic write_register(input logic idx, input logic val);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == psc_pkg::CFG_PIXEL_FORMAT)
            cur_format = val;
        else
            cur_landscape = val;
    endtask

    // Sends one byte. The sender idles cycle by cycle at the phase's rate,
    // then holds valid until the transfer. Valid stays high afterwards, so
    // back-to-back bytes need no extra step.
    task automatic send_byte(input logic [7:0] b);
        while (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        convert_byte(b);
        bytes_sent++;
    endtask

    // Mostly uniform bytes, with the all-zero and all-one values now and then.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_rgb332_extremes();
        in_idle_pct  = 20;
        out_idle_pct = 20;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hE0);  // red only
        send_byte(8'h1C);  // green only
        send_byte(8'h03);  // blue only
        send_byte(8'h92);
        send_byte(8'h49);
    endtask

    // Pairs join low byte first. A low byte left waiting when the format goes
    // back to RGB332 is dropped.
    task automatic test_rgb565_pairs();
        write_register(psc_pkg::CFG_PIXEL_FORMAT, psc_pkg::FMT_RGB565_LE);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h34);
        send_byte(8'h12);
        send_byte(8'hCD);
        send_byte(8'hAB);
        send_byte(8'h77);
        write_register(psc_pkg::CFG_PIXEL_FORMAT, psc_pkg::FMT_RGB332);
        send_byte(8'h5A);
    endtask

    task automatic test_landscape_small();
        write_register(psc_pkg::CFG_LANDSCAPE, 1'b1);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        write_register(psc_pkg::CFG_PIXEL_FORMAT, psc_pkg::FMT_RGB565_LE);
        send_byte(8'hEF);
        send_byte(8'hBE);
    endtask

    // Walks line ends in RGB332, with orientation switches in mid line.
    task automatic test_line_boundaries();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        write_register(psc_pkg::CFG_PIXEL_FORMAT, psc_pkg::FMT_RGB332);
        write_register(psc_pkg::CFG_LANDSCAPE, 1'b0);
        // Finish the current portrait line the ordinary way.
        while (src_col != 0)
            send_byte(pick_byte());
        // Landscape out to the last portrait column, then back to portrait,
        // so that the next pixel ends the line exactly.
        write_register(psc_pkg::CFG_LANDSCAPE, 1'b1);
        while (src_col < psc_pkg::FB_WIDTH - 1)
            send_byte(pick_byte());
        write_register(psc_pkg::CFG_LANDSCAPE, 1'b0);
        send_byte(pick_byte());
        // Landscape out to column 250, beyond the portrait width. Back in
        // portrait, the next pixel ends the line.
        write_register(psc_pkg::CFG_LANDSCAPE, 1'b1);
        while (src_col < 250)
            send_byte(pick_byte());
        write_register(psc_pkg::CFG_LANDSCAPE, 1'b0);
        repeat (12) send_byte(pick_byte());
    endtask

    // Random bursts of bytes. Between bursts a register is rewritten, the sender
    // pauses until the output has drained, or the next burst follows at once.
    task automatic run_random_phase(input int in_pct, input int out_pct, input int n_items);
        int sent;
        int burst;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 60);
            repeat (burst) send_byte(pick_byte());
            sent += burst;
            case ($urandom_range(0, 4))
                0: write_register(psc_pkg::CFG_PIXEL_FORMAT, 1'($urandom_range(0, 1)));
                1: write_register(psc_pkg::CFG_LANDSCAPE, 1'($urandom_range(0, 1)));
                2: settle_block();
                default: ;
            endcase
        end
    endtask

    initial begin
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_rgb332_extremes();
        test_rgb565_pairs();
        test_landscape_small();
        test_line_boundaries();
        run_random_phase(28, 48, 320);
        run_random_phase(48, 28, 320);
        run_random_phase(0, 0, 320);

        settle_block();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes and checked %0d writes across both formats and orientations.",
                 bytes_sent, writes_checked);
        $display("Frame ends seen: %0d, mismatches: %0d.", frames_seen, bad_writes);
        if (bad_writes == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
